>>> hw/rtl/gprg_pkg.sv
// gprg_pkg: shared types, constants and cordic angle table for the phase ramp generator
// no dependencies
package gprg_pkg;

  localparam int CordicN = 30;
  localparam int AxisW = 9;
  localparam int IdxW = 24;

  typedef struct packed {
    logic load;      // capture request
    logic restart;
    logic cstart;    // start cordic pass
    logic cstep;     // one cordic iteration
  } gprg_cmd_t;

  typedef struct packed {
    logic pos_done;  // positions and products ready
    logic cordic_last;
  } gprg_sts_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_POS   = 5'b00010,
    ST_PHASE = 5'b00100,
    ST_ROT   = 5'b01000,
    ST_OUT   = 5'b10000
  } gprg_state_e;

  localparam logic [2:0] RegSizes = 3'd0;
  localparam logic [2:0] RegOrigin = 3'd1;
  localparam logic [2:0] RegExtent = 3'd2;
  localparam logic [2:0] RegStepX = 3'd3;
  localparam logic [2:0] RegStepY = 3'd4;
  localparam logic [2:0] RegStepZ = 3'd5;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    begin
      case (i)
        5'd0: r = 32'h20000000; 5'd1: r = 32'h12E4051E; 5'd2: r = 32'h09FB385B;
        5'd3: r = 32'h051111D4; 5'd4: r = 32'h028B0D43; 5'd5: r = 32'h0145D7E1;
        5'd6: r = 32'h00A2F61E; 5'd7: r = 32'h00517C55; 5'd8: r = 32'h0028BE53;
        5'd9: r = 32'h00145F2F; 5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
        5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3; 5'd14: r = 32'h0000A2FA;
        5'd15: r = 32'h0000517D; 5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
        5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518; 5'd20: r = 32'h0000028C;
        5'd21: r = 32'h00000146; 5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
        5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014; 5'd26: r = 32'h0000000A;
        5'd27: r = 32'h00000005; 5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
        default: r = 32'h0;
      endcase
      return r;
    end
  endfunction

endpackage

>>> hw/rtl/gprg_ctrl.sv
// gprg_ctrl: sequencer for one request (position step, phase, cordic, output)
// depends on gprg_pkg
module gprg_ctrl import gprg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_restart_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output gprg_cmd_t cmd_o,
  input  gprg_sts_t sts_i
);
  gprg_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    cmd_o.restart = in_restart_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = ST_POS;
        end
      end
      ST_POS: begin
        if (sts_i.pos_done) state_d = ST_PHASE;
      end
      ST_PHASE: begin
        cmd_o.cstart = 1'b1;
        state_d = ST_ROT;
      end
      ST_ROT: begin
        cmd_o.cstep = 1'b1;
        if (sts_i.cordic_last) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

>>> hw/rtl/gprg_dp.sv
// gprg_dp: sweep counters, window test, index and phase products, iterative cordic
// depends on gprg_pkg
module gprg_dp import gprg_pkg::*; #(
  parameter int MaxDim = 256,
  parameter int PhaseBits = 24,
  parameter int OutFracBits = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [26:0]                   sizes_i,
  input  logic [26:0]                   origin_i,
  input  logic [26:0]                   extent_i,
  input  logic [23:0]                   step_x_i,
  input  logic [23:0]                   step_y_i,
  input  logic [23:0]                   step_z_i,
  input  gprg_cmd_t                     cmd_i,
  output gprg_sts_t                     sts_o,
  output logic                          in_window_o,
  output logic [IdxW-1:0]               buffer_index_o,
  output logic signed [OutFracBits+1:0] cos_value_o,
  output logic signed [OutFracBits+1:0] sin_value_o,
  output logic                          last_point_o
);
  localparam int OutW = OutFracBits + 2;
  localparam int PW = PhaseBits;
  // clamped axis sizes of the reset grid (32, 32, 4)
  localparam int RstNX = (MaxDim < 32) ? MaxDim : 32;
  localparam int RstNZ = (MaxDim < 4) ? MaxDim : 4;

  // axis sizes clamped to 1..MaxDim
  logic [AxisW-1:0] n [3];
  logic signed [AxisW:0] lo [3], hi [3];
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      n[a] = sizes_i[a*AxisW +: AxisW];
      if (n[a] == '0) n[a] = AxisW'(1);
      if (32'(n[a]) > MaxDim) n[a] = AxisW'(MaxDim);
      lo[a] = -$signed({2'b0, n[a][AxisW-1:1]});
      hi[a] = $signed({1'b0, n[a]}) - 10'sd1 + lo[a];
    end
  end

  // positions; reset equals first point of the reset sizes
  logic signed [AxisW:0] pos_q [3], pos_d [3];
  always_comb begin
    pos_d = pos_q;
    if (cmd_i.restart) begin
      for (int a = 0; a < 3; a++) pos_d[a] = lo[a];
    end else if (pos_q[2] >= hi[2]) begin
      pos_d[2] = lo[2];
      if (pos_q[1] >= hi[1]) begin
        pos_d[1] = lo[1];
        pos_d[0] = (pos_q[0] >= hi[0]) ? lo[0] : pos_q[0] + 10'sd1;
      end else pos_d[1] = pos_q[1] + 10'sd1;
    end else pos_d[2] = pos_q[2] + 10'sd1;
  end

  // pipeline sub-stage counter in POS: 0 positions, 1 products, 2 sums
  logic [1:0] sub_q;
  assign sts_o.pos_done = (sub_q == 2'd2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q <= '0;
      pos_q[0] <= (AxisW+1)'(-(RstNX / 2));
      pos_q[1] <= (AxisW+1)'(-(RstNX / 2));
      pos_q[2] <= (AxisW+1)'(-(RstNZ / 2));
    end else begin
      if (cmd_i.load) begin
        pos_q <= pos_d;
        sub_q <= 2'd0;
      end else if (sub_q != 2'd2) sub_q <= sub_q + 2'd1;
      else if (cmd_i.cstart) sub_q <= 2'd0;
    end
  end

  // wrapped coordinates and window test
  logic [AxisW-1:0] w [3], o [3], e [3];
  logic inwin;
  logic [AxisW:0] rel [3];
  always_comb begin
    inwin = 1'b1;
    for (int a = 0; a < 3; a++) begin
      w[a] = pos_q[a][AxisW] ? AxisW'(pos_q[a] + $signed({1'b0, n[a]})) : pos_q[a][AxisW-1:0];
      o[a] = origin_i[a*AxisW +: AxisW];
      e[a] = extent_i[a*AxisW +: AxisW];
      rel[a] = {1'b0, w[a]} - {1'b0, o[a]};
      if (w[a] < o[a] || {1'b0, w[a]} >= {1'b0, o[a]} + {1'b0, e[a]}) inwin = 1'b0;
    end
  end

  function automatic logic [PW-1:0] align(input logic [23:0] s);
    logic [55:0] t;
    begin
      t = {s, 32'b0};
      return t[55 -: PW];
    end
  endfunction

  // products registered, then sums
  logic [PW-1:0] px_q, py_q, pz_q, ph_q;
  logic [IdxW-1:0] eyz_q, ia_q, ib_q, idx_q;
  logic inwin_q, last_q;
  always_ff @(posedge clk_i) begin
    if (sub_q == 2'd0 && !cmd_i.load) begin
      px_q <= PW'(align(step_x_i) * PW'($unsigned(32'(pos_q[0]))));
      py_q <= PW'(align(step_y_i) * PW'($unsigned(32'(pos_q[1]))));
      pz_q <= PW'(align(step_z_i) * PW'($unsigned(32'(pos_q[2]))));
      eyz_q <= IdxW'(e[1] * e[2]);
      ib_q <= IdxW'(rel[1][AxisW-1:0] * e[2]) + IdxW'(rel[2][AxisW-1:0]);
      inwin_q <= inwin;
      last_q <= (pos_q[0] >= hi[0]) && (pos_q[1] >= hi[1]) && (pos_q[2] >= hi[2]);
    end
    if (sub_q == 2'd1) begin
      ph_q <= px_q + py_q + pz_q;
      ia_q <= IdxW'(rel[0][AxisW-1:0] * eyz_q);
    end
    if (sub_q == 2'd2 && cmd_i.cstart) idx_q <= ia_q + ib_q;
  end

  // iterative cordic, one iteration per cycle
  logic signed [33:0] x_q, y_q;
  logic signed [32:0] z_q;
  logic [1:0] q_q;
  logic [4:0] it_q;
  logic [31:0] t, u;
  assign t = 32'({ph_q, 32'b0} >> PW);
  assign u = t + 32'h20000000;
  assign sts_o.cordic_last = (it_q == 5'(CordicN - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.cstart) begin
      x_q <= 34'sd652032874;
      y_q <= '0;
      z_q <= $signed({3'b0, u[29:0]}) - 33'sh20000000;
      q_q <= u[31:30];
      it_q <= '0;
    end else if (cmd_i.cstep) begin
      if (!z_q[32]) begin
        x_q <= x_q - (y_q >>> it_q);
        y_q <= y_q + (x_q >>> it_q);
        z_q <= z_q - $signed({1'b0, atan_turn(it_q)});
      end else begin
        x_q <= x_q + (y_q >>> it_q);
        y_q <= y_q - (x_q >>> it_q);
        z_q <= z_q + $signed({1'b0, atan_turn(it_q)});
      end
      it_q <= it_q + 5'd1;
    end
  end

  function automatic logic signed [OutW-1:0] rnd(input logic signed [34:0] v);
    logic signed [34:0] r, lim;
    begin
      lim = 35'sd1 <<< OutFracBits;
      r = (v + (35'sd1 <<< (29 - OutFracBits))) >>> (30 - OutFracBits);
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return OutW'(r);
    end
  endfunction

  logic signed [34:0] cx, cy;
  always_comb begin
    case (q_q)
      2'd0: begin cx = 35'(x_q); cy = 35'(y_q); end
      2'd1: begin cx = -35'(y_q); cy = 35'(x_q); end
      2'd2: begin cx = -35'(x_q); cy = -35'(y_q); end
      default: begin cx = 35'(y_q); cy = -35'(x_q); end
    endcase
  end

  assign in_window_o = inwin_q;
  assign buffer_index_o = inwin_q ? idx_q : '0;
  assign cos_value_o = inwin_q ? rnd(cx) : '0;
  assign sin_value_o = inwin_q ? rnd(cy) : '0;
  assign last_point_o = last_q;
endmodule

>>> hw/rtl/grid_phase_ramp_generator.sv
// grid_phase_ramp_generator: top level, apb register file, controller and datapath
// depends on gprg_pkg, gprg_ctrl, gprg_dp
//
// usage:
//  - input channel (in_valid_i/in_ready_o, in_restart_i): each request steps the
//    3-d sweep one point (z fastest, x slowest) or restarts it at the first point
//  - output channel (out_valid_o/out_ready_i): one result per request with
//    window flag, window-relative buffer index, cos/sin phasor and last flag
//  - apb port writes/reads the six configuration registers at 4*i
// timing:
//  - one request at a time; out_valid_o rises after the products, sums and index,
//    a cordic load and 30 cordic iterations, set by the iterative cordic rotator
//  - a new request is taken only after the result is taken and the controller
//    is back in idle
// reset:
//  - registers return to defaults; the first point of the reset grid is loaded,
//    so the first non-restart request gives the second point
// stall:
//  - the result holds on the output until out_ready_i; no new request is taken
module grid_phase_ramp_generator import gprg_pkg::*; #(
  parameter int MaxDim = 256,
  parameter int PhaseBits = 24,
  parameter int OutFracBits = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [4:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          in_restart_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          out_in_window_o,
  output logic [23:0]                   out_buffer_index_o,
  output logic signed [OutFracBits+1:0] out_cos_value_o,
  output logic signed [OutFracBits+1:0] out_sin_value_o,
  output logic                          out_last_point_o
);
  logic [26:0] sizes_q, origin_q, extent_q;
  logic [23:0] stx_q, sty_q, stz_q;
  logic wr;
  logic [2:0] ra;

  assign pready = 1'b1;
  assign ra = paddr[4:2];
  assign wr = psel && penable && pwrite;

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sizes_q <= 27'd1064992;
      origin_q <= '0;
      extent_q <= 27'd1064992;
      stx_q <= '0;
      sty_q <= '0;
      stz_q <= '0;
    end else if (wr) begin
      case (ra)
        RegSizes: sizes_q <= pwdata[26:0];
        RegOrigin: origin_q <= pwdata[26:0];
        RegExtent: extent_q <= pwdata[26:0];
        RegStepX: stx_q <= pwdata[23:0];
        RegStepY: sty_q <= pwdata[23:0];
        RegStepZ: stz_q <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (ra)
      RegSizes: prdata = {5'b0, sizes_q};
      RegOrigin: prdata = {5'b0, origin_q};
      RegExtent: prdata = {5'b0, extent_q};
      RegStepX: prdata = {8'b0, stx_q};
      RegStepY: prdata = {8'b0, sty_q};
      RegStepZ: prdata = {8'b0, stz_q};
      default: prdata = '0;
    endcase
  end

  gprg_cmd_t cmd;
  gprg_sts_t sts;

  gprg_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_restart_i, .in_ready_o,
    .out_valid_o, .out_ready_i, .cmd_o(cmd), .sts_i(sts)
  );

  gprg_dp #(.MaxDim(MaxDim), .PhaseBits(PhaseBits), .OutFracBits(OutFracBits)) u_dp (
    .clk_i, .rst_ni,
    .sizes_i(sizes_q), .origin_i(origin_q), .extent_i(extent_q),
    .step_x_i(stx_q), .step_y_i(sty_q), .step_z_i(stz_q),
    .cmd_i(cmd), .sts_o(sts),
    .in_window_o(out_in_window_o), .buffer_index_o(out_buffer_index_o),
    .cos_value_o(out_cos_value_o), .sin_value_o(out_sin_value_o),
    .last_point_o(out_last_point_o)
  );

  // never take a request while a result is held
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result pending");

  // accept leads to busy next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("no busy after accept");

  // outside the window the phasor is zero
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_in_window_o |-> out_cos_value_o == '0 && out_sin_value_o == '0)
    else $error("phasor outside window");
endmodule
